// ----- design/pru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the PNG row unfilter (RGBA, 8 bits/channel).
// ----------------------------------------------------------------------------
package pru_pkg;

  // Filter method 0 row filter codes
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam int RW_W     = 13;

  // Per-pixel control that travels from the column tracker down the pipe
  typedef struct packed {
    filt_t filt;   // effective filter of the row
    logic  bad;    // row filter byte was out of range
    logic  top;    // first row of a frame: row above reads as zero
    logic  first;  // column 0: left and upper-left read as zero
    logic  last;   // last pixel of the scanline
  } item_ctl_t;

endpackage

// ----- design/pru_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_if
// Valid/ready channel interfaces for pixel input, pixel output and config.
// ----------------------------------------------------------------------------
interface pru_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] filter_type;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, frame_start, filter_type, red_in, green_in, blue_in,
                  alpha_in, input ready);
  modport sink (input valid, frame_start, filter_type, red_in, green_in, blue_in,
                alpha_in, output ready);
endinterface

interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       row_end;
  logic       bad_filter;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end,
                  bad_filter, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, row_end,
                bad_filter, output ready);
endinterface

interface pru_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] row_width;

  modport source (output valid, row_width, input ready);
  modport sink (input valid, row_width, output ready);
endinterface

// ----- design/pru_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/pru_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ctrl
// Column tracker: row position, frame/top-row flag and per-row filter decode.
// ----------------------------------------------------------------------------
module pru_ctrl #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        accept,
  input  logic                                        frame_start,
  input  logic [7:0]                                  filter_type,
  input  logic [pru_pkg::RW_W-1:0]                    row_width,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] col,
  output pru_pkg::item_ctl_t                          ctl
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = (CW + 1 > pru_pkg::RW_W) ? CW + 1 : pru_pkg::RW_W;
  localparam logic [CMPW-1:0] MAXW = CMPW'(MAX_WIDTH);

  logic [CW-1:0]      col_r, col_nxt;
  logic               top_r, top_nxt;
  pru_pkg::filt_t     filt_r, filt_nxt;
  logic               bad_r, bad_nxt;
  logic [CMPW-1:0]    width_ext, width_eff, col_inc;
  logic               first, top_cur, last;
  logic               ft_bad;

  // Clamp the row width into 1..MAX_WIDTH
  always_comb begin
    width_ext = CMPW'(row_width);
    if (width_ext == '0) begin
      width_eff = CMPW'(1);
    end else if (width_ext > MAXW) begin
      width_eff = MAXW;
    end else begin
      width_eff = width_ext;
    end
  end

  // Position of the current beat; frame start restarts the row
  always_comb begin
    col     = frame_start ? '0 : col_r;
    top_cur = frame_start ? 1'b1 : top_r;
    first   = (col == '0);
    col_inc = CMPW'(col) + CMPW'(1);
    last    = (col_inc >= width_eff);
    ft_bad  = (filter_type > 8'(pru_pkg::FILT_PAETH));
  end

  // Sample the filter byte at column 0, otherwise hold the row's filter
  always_comb begin
    filt_nxt = filt_r;
    bad_nxt  = bad_r;
    if (first) begin
      bad_nxt  = ft_bad;
      filt_nxt = ft_bad ? pru_pkg::FILT_NONE : pru_pkg::filt_t'(filter_type[2:0]);
    end
  end

  always_comb begin
    ctl.filt  = filt_nxt;
    ctl.bad   = bad_nxt;
    ctl.top   = top_cur;
    ctl.first = first;
    ctl.last  = last;
  end

  // Advance the column; wrap and drop the top-row flag at row end
  always_comb begin
    col_nxt = last ? '0 : col_inc[CW-1:0];
    top_nxt = last ? 1'b0 : top_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      top_r  <= 1'b1;
      filt_r <= pru_pkg::FILT_NONE;
      bad_r  <= 1'b0;
    end else if (accept) begin
      col_r  <= col_nxt;
      top_r  <= top_nxt;
      filt_r <= filt_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

// ----- design/pru_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_lane
// One channel lane: predictor select and modulo-256 reconstruction.
// ----------------------------------------------------------------------------
module pru_lane (
  input  pru_pkg::filt_t                filt,
  input  logic [pru_pkg::CHAN_W-1:0]    f,
  input  logic [pru_pkg::CHAN_W-1:0]    a,
  input  logic [pru_pkg::CHAN_W-1:0]    b,
  input  logic [pru_pkg::CHAN_W-1:0]    c,
  output logic [pru_pkg::CHAN_W-1:0]    recon
);

  localparam int DW = pru_pkg::CHAN_W + 2;

  logic signed [DW-1:0]          sa, sb, sc, da, db, dc, pa, pb, pc;
  logic [pru_pkg::CHAN_W-1:0]    paeth, pred;
  logic [pru_pkg::CHAN_W:0]      avg_sum;

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  always_comb begin
    sa = DW'(a);
    sb = DW'(b);
    sc = DW'(c);
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    pa = (da < 0) ? -da : da;
    pb = (db < 0) ? -db : db;
    pc = (dc < 0) ? -dc : dc;
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  // Select predictor by row filter
  always_comb begin
    avg_sum = {1'b0, a} + {1'b0, b};
    unique case (filt)
      pru_pkg::FILT_SUB:   pred = a;
      pru_pkg::FILT_UP:    pred = b;
      pru_pkg::FILT_AVG:   pred = avg_sum[pru_pkg::CHAN_W:1];
      pru_pkg::FILT_PAETH: pred = paeth;
      default:             pred = '0;
    endcase
  end

  assign recon = f + pred;

endmodule

// ----- design/png_row_unfilter_rgba8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_rgba8
// PNG filter method 0 reconstruction for 8-bit RGBA pixel streams.
// ----------------------------------------------------------------------------
// Takes one filtered pixel per beat and returns one reconstructed pixel per
// beat, sustaining one pixel every clock cycle unless the output stalls; pixels
// pass stage 1, then the output register. The rate is set by the left-pixel
// loop: a pixel's reconstruction feeds the Sub/Average/Paeth predictor of the
// next one, and that loop closes through left_r alone across four channel
// lanes. The previous row lives in a MAX_WIDTH x 32 line RAM read at accept,
// ahead of use, with a forward path for a read that meets the write of the
// same column. The line RAM needs no clearing pass; the first row of a frame
// reads the row above as zero. Program row_width only while the block is idle.
// ----------------------------------------------------------------------------
module png_row_unfilter_rgba8 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  pru_in_if.sink       in_chan,
  pru_out_if.source    out_chan,
  pru_cfg_if.sink      cfg_chan
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = pru_pkg::PIX_W;
  localparam int BW = pru_pkg::CHAN_W;

  logic [pru_pkg::RW_W-1:0] row_width_r;

  logic                in_acc;
  logic [CW-1:0]       col_cur;
  pru_pkg::item_ctl_t  ctl_cur;

  logic                s1_valid_r;
  logic [CW-1:0]       s1_col_r;
  pru_pkg::item_ctl_t  s1_ctl_r;
  logic [PW-1:0]       s1_px_r;
  logic                s1_adv;

  logic                byp_r;
  logic [PW-1:0]       byp_px_r;
  logic [PW-1:0]       ram_rdata;

  logic [PW-1:0]       left_r;
  logic [PW-1:0]       ul_r;
  logic [PW-1:0]       up_px, left_px, ul_px, recon_px;

  logic                out_valid_r;
  logic [PW-1:0]       out_px_r;
  logic                out_end_r;
  logic                out_bad_r;

  // Config register: always ready
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= pru_pkg::RW_W'(1);
    end else if (cfg_chan.valid) begin
      row_width_r <= cfg_chan.row_width;
    end
  end

  // Handshake: stage 1 advances when the output register is free or drains
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Column and filter tracking
  pru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .frame_start (in_chan.frame_start),
    .filter_type (in_chan.filter_type),
    .row_width   (row_width_r),
    .col         (col_cur),
    .ctl         (ctl_cur)
  );

  // Line buffer: read at accept, write when stage 1 advances
  pru_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (recon_px),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  // Capture stage-1 item; forward a same-column write landing on this read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        byp_r      <= s1_adv && (s1_col_r == col_cur);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= col_cur;
      s1_ctl_r <= ctl_cur;
      s1_px_r  <= {in_chan.alpha_in, in_chan.blue_in, in_chan.green_in, in_chan.red_in};
      byp_px_r <= recon_px;
    end
  end

  // Neighbor pixels for the predictor
  always_comb begin
    up_px   = s1_ctl_r.top ? '0 : (byp_r ? byp_px_r : ram_rdata);
    left_px = s1_ctl_r.first ? '0 : left_r;
    ul_px   = s1_ctl_r.first ? '0 : ul_r;
  end

  // Four channel lanes side by side
  for (genvar k = 0; k < pru_pkg::NUM_CHAN; k++) begin : g_lane
    pru_lane u_lane (
      .filt  (s1_ctl_r.filt),
      .f     (s1_px_r[BW*k +: BW]),
      .a     (left_px[BW*k +: BW]),
      .b     (up_px[BW*k +: BW]),
      .c     (ul_px[BW*k +: BW]),
      .recon (recon_px[BW*k +: BW])
    );
  end

  // Hold left and upper-left neighbors for the next pixel
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_r <= recon_px;
      ul_r   <= up_px;
    end
  end

  // Merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_px_r  <= recon_px;
      out_end_r <= s1_ctl_r.last;
      out_bad_r <= s1_ctl_r.bad;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.red_out    = out_px_r[BW*0 +: BW];
  assign out_chan.green_out  = out_px_r[BW*1 +: BW];
  assign out_chan.blue_out   = out_px_r[BW*2 +: BW];
  assign out_chan.alpha_out  = out_px_r[BW*3 +: BW];
  assign out_chan.row_end    = out_end_r;
  assign out_chan.bad_filter = out_bad_r;

endmodule

// ----- tb/sv/png_row_unfilter_rgba8_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_rgba8_checker
// Watches the pixel, result and config channels. Predicts every reconstructed
// pixel from the filtered beats and compares each result beat, in order.
// ----------------------------------------------------------------------------
module png_row_unfilter_rgba8_checker
  import pru_pkg::*;
#(
  parameter int MAX_COLS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  pru_in_if    in_mon,
  pru_out_if   out_mon,
  pru_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       bad_filter;
  } pixel_beat_t;

  // Shadow of the unfilter state
  logic [PIX_W-1:0] prev_row [MAX_COLS];
  logic [PIX_W-1:0] left_q;
  logic [PIX_W-1:0] upleft_q;
  int unsigned      col_q;
  filt_t            row_filt_q;
  logic             top_row_q;
  logic             row_bad_q;
  logic [RW_W-1:0]  row_width_q;

  pixel_beat_t expected_pixels [$];

  // Paeth: pick a, b or c by least distance to a + b - c; earlier wins ties
  function automatic logic [7:0] paeth_choose(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Rebuild one pixel and advance the row position
  task automatic unfilter_pixel(input logic frame_start, input logic [7:0] filter_byte,
                                input logic [PIX_W-1:0] filtered, output pixel_beat_t res);
    int unsigned      eff_width;
    int unsigned      col;
    int               k;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] above_left;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] recon;
    logic [7:0]       a;
    logic [7:0]       b;
    logic [7:0]       c;
    logic [7:0]       pred;

    eff_width = (row_width_q == 0) ? 1 :
                (row_width_q > MAX_COLS) ? MAX_COLS : int'(row_width_q);
    if (frame_start) begin
      col_q     = 0;
      top_row_q = 1'b1;
    end
    col = (col_q >= MAX_COLS) ? 0 : col_q;

    // Sample the row filter on column 0; out-of-range codes decode as None
    if (col == 0) begin
      if (filter_byte > 8'(FILT_PAETH)) begin
        row_filt_q = FILT_NONE;
        row_bad_q  = 1'b1;
      end else begin
        row_filt_q = filt_t'(filter_byte[2:0]);
        row_bad_q  = 1'b0;
      end
    end

    above      = top_row_q ? '0 : prev_row[col];
    above_left = (col == 0) ? '0 : upleft_q;
    left       = (col == 0) ? '0 : left_q;

    for (k = 0; k < NUM_CHAN; k++) begin
      a = left[CHAN_W*k +: CHAN_W];
      b = above[CHAN_W*k +: CHAN_W];
      c = above_left[CHAN_W*k +: CHAN_W];
      case (row_filt_q)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_choose(a, b, c);
        default:    pred = '0;
      endcase
      recon[CHAN_W*k +: CHAN_W] = filtered[CHAN_W*k +: CHAN_W] + pred;
    end

    upleft_q      = above;
    left_q        = recon;
    prev_row[col] = recon;

    res.red        = recon[7:0];
    res.green      = recon[15:8];
    res.blue       = recon[23:16];
    res.alpha      = recon[31:24];
    res.row_end    = (col + 1 >= eff_width);
    res.bad_filter = row_bad_q;

    if (res.row_end) begin
      col_q     = 0;
      top_row_q = 1'b0;
    end else begin
      col_q = col + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Predict on every pixel beat, compare on every result beat
  always @(posedge clk) begin
    pixel_beat_t want;
    pixel_beat_t got;
    if (!rst_n) begin
      left_q      = '0;
      upleft_q    = '0;
      col_q       = 0;
      row_filt_q  = FILT_NONE;
      top_row_q   = 1'b1;
      row_bad_q   = 1'b0;
      row_width_q = RW_W'(1);
      expected_pixels.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) row_width_q = cfg_mon.row_width;
      if (in_mon.valid && in_mon.ready) begin
        unfilter_pixel(in_mon.frame_start, in_mon.filter_type,
                       {in_mon.alpha_in, in_mon.blue_in, in_mon.green_in, in_mon.red_in},
                       want);
        expected_pixels.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.red        = out_mon.red_out;
        got.green      = out_mon.green_out;
        got.blue       = out_mon.blue_out;
        got.alpha      = out_mon.alpha_out;
        got.row_end    = out_mon.row_end;
        got.bad_filter = out_mon.bad_filter;
        if (expected_pixels.size() == 0) begin
          $error("result beat arrived with no pixel pending");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.red, got.red);
          check_field("green_out", want.green, got.green);
          check_field("blue_out", want.blue, got.blue);
          check_field("alpha_out", want.alpha, got.alpha);
          check_field("row_end", 8'(want.row_end), 8'(got.row_end));
          check_field("bad_filter", 8'(want.bad_filter), 8'(got.bad_filter));
          checked_count++;
        end
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

// ----- tb/sv/png_row_unfilter_rgba8_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_row_unfilter_rgba8_tb
// Drives filtered RGBA scanlines through the row unfilter: a directed pass
// over every filter type, invalid codes and frame restarts, a long top row at
// the largest widths, then random rows at many widths with bursty input and a
// stalling output. The checker module predicts and compares every result beat.
// ----------------------------------------------------------------------------
module png_row_unfilter_rgba8_tb;
  import pru_pkg::*;

  localparam int MAX_COLS     = 4096;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DRAIN_TAIL   = 8;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_CHOPPY,
    SINK_BURSTY
  } sink_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pru_in_if  in_chan ();
  pru_out_if out_chan ();
  pru_cfg_if cfg_chan ();

  int mismatch_total;
  int pixels_in_flight;
  int pixels_checked;

  // Stimulus bookkeeping
  logic [RW_W-1:0] cur_width = RW_W'(1);
  int unsigned     trk_col;
  int              burst_left;
  int              width_settings;
  int              rows_by_filter [6];
  int              cycle_count;

  // Receiver pattern state
  sink_mode_t sink_mode;
  int         sink_mode_left;
  int         stall_left;

  png_row_unfilter_rgba8 #(
    .MAX_WIDTH (MAX_COLS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  png_row_unfilter_rgba8_checker #(
    .MAX_COLS (MAX_COLS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .fail_count    (mismatch_total),
    .pending_count (pixels_in_flight),
    .checked_count (pixels_checked)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL png_row_unfilter_rgba8");
      $finish;
    end
  end

  // Result backpressure: switch between open, choppy and long-stall patterns
  always @(negedge clk) begin
    logic next_ready;
    if (sink_mode_left == 0) begin
      sink_mode      = sink_mode_t'($urandom_range(2));
      sink_mode_left = $urandom_range(16, 128);
    end
    sink_mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else begin
      case (sink_mode)
        SINK_OPEN:   next_ready = 1'b1;
        SINK_CHOPPY: next_ready = ($urandom_range(3) != 0);
        default: begin
          if ($urandom_range(9) == 0) begin
            stall_left = $urandom_range(1, 7);
            next_ready = 1'b0;
          end else begin
            next_ready = 1'b1;
          end
        end
      endcase
    end
    out_chan.ready <= next_ready;
  end

  // Biased byte: corner values often, to hit wraps and Paeth ties
  function automatic logic [7:0] rand_byte();
    logic [7:0] corners [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(3) == 0) return corners[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  // Mostly legal filter codes, sometimes an out-of-range byte
  function automatic logic [7:0] pick_filter();
    if ($urandom_range(7) == 0) return 8'($urandom_range(int'(FILT_PAETH) + 1, 255));
    return 8'($urandom_range(int'(FILT_PAETH)));
  endfunction

  // Send one filtered pixel; called and returns at a falling edge
  task automatic push_pixel(input logic fs, input logic [7:0] ft, input logic [PIX_W-1:0] px);
    int unsigned eff_width;
    int          gap;
    eff_width = (cur_width == 0) ? 1 : (cur_width > MAX_COLS) ? MAX_COLS : int'(cur_width);
    if (fs) trk_col = 0;
    if (trk_col == 0) begin
      if (ft > 8'(FILT_PAETH)) rows_by_filter[5]++;
      else rows_by_filter[ft]++;
    end
    trk_col = (trk_col + 1 >= eff_width) ? 0 : trk_col + 1;

    // Idle between bursts
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;

    in_chan.valid       <= 1'b1;
    in_chan.frame_start <= fs;
    in_chan.filter_type <= ft;
    in_chan.red_in      <= px[7:0];
    in_chan.green_in    <= px[15:8];
    in_chan.blue_in     <= px[23:16];
    in_chan.alpha_in    <= px[31:24];
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Hold the sender until every pixel has come back, then let the pipe settle
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (pixels_in_flight != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic write_row_width(input logic [RW_W-1:0] w);
    drain_results();
    cfg_chan.valid     <= 1'b1;
    cfg_chan.row_width <= w;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    cur_width = w;
    width_settings++;
  endtask

  // Plain row data; filter byte only matters at column 0
  task automatic stream_pixels(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      push_pixel(1'b0, (trk_col == 0) ? pick_filter() : 8'($urandom), rand_pixel());
    end
  endtask

  // Well-formed rows with occasional frame restarts, some of them mid-row
  task automatic run_random_rows(input int n);
    int         i;
    logic       fs;
    logic [7:0] ft;
    for (i = 0; i < n; i++) begin
      fs = ($urandom_range(149) == 0);
      if (trk_col == 0 && $urandom_range(15) == 0) fs = 1'b1;
      ft = (fs || trk_col == 0) ? pick_filter() : 8'($urandom);
      push_pixel(fs, ft, rand_pixel());
    end
  endtask

  initial begin
    logic [7:0]      dir_filters [5];
    logic [RW_W-1:0] w;
    int              random_sent;
    int              n;
    int              i;
    int              j;

    dir_filters = '{8'(FILT_SUB), 8'(FILT_UP), 8'(FILT_AVG), 8'(FILT_PAETH), 8'hFF};

    in_chan.valid       = 1'b0;
    in_chan.frame_start = 1'b0;
    in_chan.filter_type = '0;
    in_chan.red_in      = '0;
    in_chan.green_in    = '0;
    in_chan.blue_in     = '0;
    in_chan.alpha_in    = '0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.row_width  = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset width is one pixel: each beat ends its row; Up wraps past 255
    push_pixel(1'b1, 8'(FILT_SUB), 32'hFFFF_FFFF);
    push_pixel(1'b0, 8'(FILT_UP), 32'h0403_0201);

    // Three-pixel rows: None with extreme bytes, then every filter and a bad code
    write_row_width(RW_W'(3));
    push_pixel(1'b1, 8'(FILT_NONE), 32'h7F80_FF00);
    push_pixel(1'b0, 8'($urandom), 32'hFE01_00FF);
    push_pixel(1'b0, 8'($urandom), 32'hCC33_AA55);
    for (i = 0; i < 5; i++) begin
      for (j = 0; j < 3; j++) begin
        push_pixel(1'b0, (j == 0) ? dir_filters[i] : 8'($urandom), rand_pixel());
      end
    end

    // An invalid code just past Paeth, then a frame restart in the middle of that row
    push_pixel(1'b0, 8'(FILT_PAETH) + 8'd1, rand_pixel());
    push_pixel(1'b0, 8'($urandom), rand_pixel());
    push_pixel(1'b1, 8'(FILT_PAETH), rand_pixel());

    // Long top row at full width; the row above reads as zero throughout
    write_row_width(RW_W'(MAX_COLS));
    push_pixel(1'b1, 8'(FILT_SUB), rand_pixel());
    stream_pixels(99);
    // Oversized width mid-row must clamp to the line length
    write_row_width('1);
    stream_pixels(60);

    // Width zero acts as one pixel per row; the first beat ends the long row
    write_row_width('0);
    run_random_rows(60);

    // Random widths, mostly narrow so rows turn over often
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       w = '0;
        1:       w = RW_W'(1);
        2, 3, 4: w = RW_W'($urandom_range(2, 8));
        5, 6, 7: w = RW_W'($urandom_range(9, 64));
        default: w = RW_W'($urandom_range(65, 300));
      endcase
      write_row_width(w);
      n = $urandom_range(40, 200);
      // Restart the frame so a wider row never reads columns left unwritten
      push_pixel(1'b1, pick_filter(), rand_pixel());
      run_random_rows(n - 1);
      random_sent += n;
    end

    drain_results();
    $display("Checked %0d pixel beats across %0d row-width settings (0, 1, 3, 4096, 8191, random).",
             pixels_checked, width_settings);
    $display("Rows started: none %0d, sub %0d, up %0d, average %0d, paeth %0d, bad code %0d.",
             rows_by_filter[0], rows_by_filter[1], rows_by_filter[2], rows_by_filter[3],
             rows_by_filter[4], rows_by_filter[5]);
    if (mismatch_total == 0) begin
      $display("PASS png_row_unfilter_rgba8");
    end else begin
      $display("FAIL png_row_unfilter_rgba8");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pru_pkg.sv
design/pru_if.sv
design/pru_ram.sv
design/pru_ctrl.sv
design/pru_lane.sv
design/png_row_unfilter_rgba8.sv
tb/sv/png_row_unfilter_rgba8_checker.sv
tb/sv/png_row_unfilter_rgba8_tb.sv
